>>> rtl/sswp_pkg.sv
package sswp_pkg;

   // Payload and register widths.
   localparam int FORCE_W    = 18;
   localparam int NET_W      = 19;
   localparam int POS_W      = 17;
   localparam int VEL_W      = 19;
   localparam int BRK_W      = 17;
   localparam int KIN_W      = 17;
   localparam int SLOPE_W    = 15;
   localparam int VMAX_W     = 18;
   localparam int LAG_W      = 16;
   localparam int PERIOD_W   = 16;
   localparam int DELAY_W    = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Shared multiplier: 20 x 16 bit unsigned, registered product.
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 16;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Register reset values.
   localparam logic [BRK_W-1:0]    BRK_RESET    = BRK_W'(6226);
   localparam logic [KIN_W-1:0]    KIN_RESET    = KIN_W'(5243);
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(13722);
   localparam logic [VMAX_W-1:0]   VMAX_RESET   = VMAX_W'(32768);
   localparam logic [LAG_W-1:0]    LAG_RESET    = '0;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(655);
   localparam logic [DELAY_W-1:0]  DELAY_RESET  = '0;

   // Full lock in Q1.15.
   localparam int POS_LIMIT = 32768;

   typedef enum logic [2:0] {
      REG_BREAKAWAY = 3'd0,
      REG_KINETIC   = 3'd1,
      REG_SLOPE     = 3'd2,
      REG_MAX_SPEED = 3'd3,
      REG_LAG       = 3'd4,
      REG_PERIOD    = 3'd5,
      REG_DELAY     = 3'd6
   } csr_reg_type;

   typedef enum logic [3:0] {
      OP_NOP      = 4'd0,
      OP_ACCEPT   = 4'd1,
      OP_WRITE    = 4'd2,
      OP_READ     = 4'd3,
      OP_FRICTION = 4'd4,
      OP_SPEED    = 4'd5,
      OP_LAG      = 4'd6,
      OP_POS_MUL  = 4'd7,
      OP_POS_ADD  = 4'd8,
      OP_OUTPUT   = 4'd9
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER       = 3'd0,
      COND_NO_ITEM     = 3'd1,
      COND_PERIOD_ZERO = 3'd2,
      COND_STUCK       = 3'd3,
      COND_LAG_OFF     = 3'd4,
      COND_OUT_BUSY    = 3'd5
   } cond_type;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_READ     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_FRICTION = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SPEED    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LAG      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_POS_MUL  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_POS_ADD  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_OUTPUT   = 4'd8;

   // One control word: the operation, a jump taken when the condition holds,
   // and whether the fall-through goes back to the wait step.
   typedef struct packed {
      uop_type           op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } uword_type;

   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      unique case (step)
         STEP_WAIT:     w = '{OP_ACCEPT,   COND_NO_ITEM,     STEP_WAIT,    1'b0};
         STEP_WRITE:    w = '{OP_WRITE,    COND_PERIOD_ZERO, STEP_OUTPUT,  1'b0};
         STEP_READ:     w = '{OP_READ,     COND_NEVER,       STEP_WAIT,    1'b0};
         STEP_FRICTION: w = '{OP_FRICTION, COND_STUCK,       STEP_POS_MUL, 1'b0};
         STEP_SPEED:    w = '{OP_SPEED,    COND_LAG_OFF,     STEP_POS_MUL, 1'b0};
         STEP_LAG:      w = '{OP_LAG,      COND_NEVER,       STEP_WAIT,    1'b0};
         STEP_POS_MUL:  w = '{OP_POS_MUL,  COND_NEVER,       STEP_WAIT,    1'b0};
         STEP_POS_ADD:  w = '{OP_POS_ADD,  COND_NEVER,       STEP_WAIT,    1'b0};
         STEP_OUTPUT:   w = '{OP_OUTPUT,   COND_OUT_BUSY,    STEP_OUTPUT,  1'b1};
         default:       w = '{OP_NOP,      COND_NEVER,       STEP_WAIT,    1'b1};
      endcase
      return w;
   endfunction

endpackage

>>> rtl/sswp_if.sv
interface sswp_req_if;
   import sswp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FORCE_W-1:0] servo_drive;
   logic signed [FORCE_W-1:0] driver_force;

   modport source (output valid, output servo_drive, output driver_force, input ready);
   modport sink   (input valid, input servo_drive, input driver_force, output ready);
endinterface

interface sswp_rsp_if;
   import sswp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] wheel_position;
   logic signed [VEL_W-1:0] wheel_velocity;
   logic                    is_moving;

   modport source (output valid, output wheel_position, output wheel_velocity,
                   output is_moving, input ready);
   modport sink   (input valid, input wheel_position, input wheel_velocity,
                   input is_moving, output ready);
endinterface

>>> rtl/sswp_ram.sv
module sswp_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> rtl/stick_slip_wheel_plant.sv
// Stick-slip steering wheel plant. Each item carries a servo force and a driver force; their
// sum goes into a history ring and the force from delay_frames items back (limited to what has
// been written) drives a static/kinetic friction model, an optional velocity lag and a clamped
// position integrator. One result item is returned per input item. A small microcode program
// steps one shared 20x16 multiplier through the speed, lag and position products. It skips
// the speed and lag steps when the wheel stays or falls at rest, the lag step when moving
// without lag, and jumps to the output when frame_period is zero (state untouched, current
// values reported). The next item is accepted the cycle after a result is handed to the output
// register. The user must write registers (APB port, byte address 4*index) while idle; not enforced.
module stick_slip_wheel_plant #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   sswp_req_if.sink                           req_if,
   sswp_rsp_if.source                         rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sswp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sswp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sswp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import sswp_pkg::*;

   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W  = ((FILL_W > DELAY_W) ? FILL_W : DELAY_W) + 1;
   localparam int EXC_W  = NET_W + 1;
   localparam int SUM_W  = POS_W + 5;
   localparam int RND_W  = PROD_W - 16;
   localparam int SP_W   = PROD_W - 12;

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
   localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'(POS_LIMIT);
   localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI;

   // Configuration registers.
   logic [BRK_W-1:0]    brk_ff;
   logic [KIN_W-1:0]    kin_ff;
   logic [SLOPE_W-1:0]  slope_ff;
   logic [VMAX_W-1:0]   vmax_ff;
   logic [LAG_W-1:0]    lag_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [DELAY_W-1:0]  delay_ff;

   logic       csr_write;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff    <= BRK_RESET;
         kin_ff    <= KIN_RESET;
         slope_ff  <= SLOPE_RESET;
         vmax_ff   <= VMAX_RESET;
         lag_ff    <= LAG_RESET;
         period_ff <= PERIOD_RESET;
         delay_ff  <= DELAY_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            REG_BREAKAWAY: brk_ff    <= csr_pwdata[BRK_W-1:0];
            REG_KINETIC:   kin_ff    <= csr_pwdata[KIN_W-1:0];
            REG_SLOPE:     slope_ff  <= csr_pwdata[SLOPE_W-1:0];
            REG_MAX_SPEED: vmax_ff   <= csr_pwdata[VMAX_W-1:0];
            REG_LAG:       lag_ff    <= csr_pwdata[LAG_W-1:0];
            REG_PERIOD:    period_ff <= csr_pwdata[PERIOD_W-1:0];
            REG_DELAY:     delay_ff  <= csr_pwdata[DELAY_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BREAKAWAY: csr_prdata = CSR_DATA_W'(brk_ff);
         REG_KINETIC:   csr_prdata = CSR_DATA_W'(kin_ff);
         REG_SLOPE:     csr_prdata = CSR_DATA_W'(slope_ff);
         REG_MAX_SPEED: csr_prdata = CSR_DATA_W'(vmax_ff);
         REG_LAG:       csr_prdata = CSR_DATA_W'(lag_ff);
         REG_PERIOD:    csr_prdata = CSR_DATA_W'(period_ff);
         REG_DELAY:     csr_prdata = CSR_DATA_W'(delay_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Sequencer.
   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         uword;
   logic              cond_true;

   // Datapath state.
   logic [NET_W-1:0]        net_ff;
   logic [PTR_W-1:0]        wptr_ff;
   logic [PTR_W-1:0]        newest_ff;
   logic [FILL_W-1:0]       fill_ff;
   logic                    moving_ff;
   logic signed [VEL_W-1:0] velocity_ff;
   logic signed [POS_W-1:0] position_ff;
   logic signed [VEL_W-1:0] vt_ff;
   logic                    f_neg_ff;
   logic                    sign_ff;
   logic [PROD_W-1:0]       prod_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_pos_ff;
   logic signed [VEL_W-1:0] rsp_vel_ff;
   logic                    rsp_moving_ff;

   logic period_zero, req_take, rsp_busy, lag_off, stuck;

   assign uword       = ucode_rom(step_ff);
   assign period_zero = (period_ff == '0);
   assign lag_off     = (lag_ff == '0);
   assign rsp_busy    = rsp_valid_ff & ~rsp_if.ready;
   assign req_if.ready = (uword.op == OP_ACCEPT) & ~reset;
   assign req_take     = req_if.ready & req_if.valid;

   always_comb begin
      unique case (uword.cond)
         COND_NEVER:       cond_true = 1'b0;
         COND_NO_ITEM:     cond_true = ~req_if.valid;
         COND_PERIOD_ZERO: cond_true = period_zero;
         COND_STUCK:       cond_true = stuck;
         COND_LAG_OFF:     cond_true = lag_off;
         COND_OUT_BUSY:    cond_true = rsp_busy;
         default:          cond_true = 1'b0;
      endcase
   end

   always_comb begin
      priority if (cond_true) begin
         step_in = uword.target;
      end else if (uword.last) begin
         step_in = STEP_WAIT;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // History ring: read address is newest minus the delay, the delay being
   // limited to the entries written so far.
   logic [CMP_W-1:0] fill_m1, delay_ext, back, newest_ext, idx_wide;
   logic [PTR_W-1:0] rd_idx;
   logic [NET_W-1:0] f_rd;
   logic             wr_en;

   always_comb begin
      fill_m1    = CMP_W'(fill_ff) - 1'b1;
      delay_ext  = CMP_W'(delay_ff);
      back       = (delay_ext > fill_m1) ? fill_m1 : delay_ext;
      newest_ext = CMP_W'(newest_ff);
      if (newest_ext >= back) begin
         idx_wide = newest_ext - back;
      end else begin
         idx_wide = newest_ext + CMP_W'(HISTORY_DEPTH) - back;
      end
      rd_idx = idx_wide[PTR_W-1:0];
   end

   assign wr_en = (uword.op == OP_WRITE) & ~period_zero;

   sswp_ram #(
      .WIDTH (NET_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (net_ff),
      .rd_en   (uword.op == OP_READ),
      .rd_addr (rd_idx),
      .rd_data (f_rd)
   );

   // Friction decision on the delayed force.
   logic                    f_neg, moving_now, excess_pos;
   logic [NET_W-1:0]        mag;
   logic signed [EXC_W-1:0] excess;

   always_comb begin
      f_neg      = f_rd[NET_W-1];
      mag        = f_neg ? (~f_rd + 1'b1) : f_rd;
      moving_now = moving_ff | (mag >= {2'b00, brk_ff});
      excess     = $signed({1'b0, mag}) - $signed({3'b000, kin_ff});
      excess_pos = ~excess[EXC_W-1] & (excess != '0);
      stuck      = ~moving_now | ~excess_pos;
   end

   // Target speed, lag difference and rounded products.
   logic [PROD_W-1:0]       sp_sum, rnd_sum;
   logic [SP_W-1:0]         sp_wide;
   logic [VMAX_W-1:0]       sp_cap;
   logic signed [VEL_W-1:0] vt;
   logic signed [EXC_W-1:0] d;
   logic [EXC_W-1:0]        d_mag;
   logic [RND_W-1:0]        r;
   logic signed [VEL_W+1:0] lag_sum;
   logic [VEL_W-1:0]        v_mag;
   logic signed [SUM_W-1:0] pos_sum, pos_clamped;

   always_comb begin
      sp_sum  = prod_ff + PROD_W'(2048);
      sp_wide = sp_sum[PROD_W-1:12];
      sp_cap  = (sp_wide > SP_W'(vmax_ff)) ? vmax_ff : sp_wide[VMAX_W-1:0];
      vt      = f_neg_ff ? $signed({1'b0, sp_cap}) : -$signed({1'b0, sp_cap});
      d       = $signed({velocity_ff[VEL_W-1], velocity_ff}) - $signed({vt[VEL_W-1], vt});
      d_mag   = d[EXC_W-1] ? (~d + 1'b1) : d;
      rnd_sum = prod_ff + PROD_W'(32768);
      r       = rnd_sum[PROD_W-1:16];
      lag_sum = $signed({{2{vt_ff[VEL_W-1]}}, vt_ff})
              + (sign_ff ? -$signed({1'b0, r}) : $signed({1'b0, r}));
      v_mag   = velocity_ff[VEL_W-1] ? (~velocity_ff + 1'b1) : velocity_ff;
      pos_sum = $signed({{(SUM_W-POS_W){position_ff[POS_W-1]}}, position_ff})
              + (sign_ff ? -$signed({2'b00, r}) : $signed({2'b00, r}));
      priority if (pos_sum > POS_HI) begin
         pos_clamped = POS_HI;
      end else if (pos_sum < POS_LO) begin
         pos_clamped = POS_LO;
      end else begin
         pos_clamped = pos_sum;
      end
   end

   // Shared multiplier operand selection.
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;

   always_comb begin
      unique case (uword.op)
         OP_FRICTION: begin
            mul_a = excess[MUL_A_W-1:0];
            mul_b = {1'b0, slope_ff};
         end
         OP_SPEED: begin
            mul_a = d_mag;
            mul_b = lag_ff;
         end
         OP_POS_MUL: begin
            mul_a = {1'b0, v_mag};
            mul_b = period_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (req_take) begin
         net_ff <= NET_W'($signed({req_if.servo_drive[FORCE_W-1], req_if.servo_drive})
                        + $signed({req_if.driver_force[FORCE_W-1], req_if.driver_force}));
      end
      if (wr_en) begin
         newest_ff <= wptr_ff;
      end
      if (uword.op == OP_FRICTION) begin
         f_neg_ff <= f_neg;
      end
      if (uword.op == OP_SPEED) begin
         vt_ff   <= vt;
         sign_ff <= d[EXC_W-1];
      end
      if (uword.op == OP_POS_MUL) begin
         sign_ff <= velocity_ff[VEL_W-1];
      end
      if ((uword.op == OP_OUTPUT) && !rsp_busy) begin
         rsp_pos_ff    <= position_ff;
         rsp_vel_ff    <= velocity_ff;
         rsp_moving_ff <= moving_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         moving_ff    <= 1'b0;
         velocity_ff  <= '0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (wr_en) begin
            wptr_ff <= (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
            if (fill_ff != FILL_FULL) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (uword.op == OP_FRICTION) begin
            if (stuck) begin
               velocity_ff <= '0;
               moving_ff   <= 1'b0;
            end else begin
               moving_ff <= 1'b1;
            end
         end
         if ((uword.op == OP_SPEED) && lag_off) begin
            velocity_ff <= vt;
         end
         if (uword.op == OP_LAG) begin
            velocity_ff <= lag_sum[VEL_W-1:0];
         end
         if (uword.op == OP_POS_ADD) begin
            position_ff <= pos_clamped[POS_W-1:0];
         end
         if ((uword.op == OP_OUTPUT) && !rsp_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.wheel_position = rsp_pos_ff;
   assign rsp_if.wheel_velocity = rsp_vel_ff;
   assign rsp_if.is_moving      = rsp_moving_ff;

endmodule

>>> tb/sv/tb.sv
module tb;
   import sswp_pkg::*;

   localparam int HIST_DEPTH    = 16;
   localparam int FORCE_MAX     = 2 ** (FORCE_W - 1) - 1;
   localparam int FORCE_MIN     = -(2 ** (FORCE_W - 1));
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic signed [FORCE_W-1:0] servo;
      logic signed [FORCE_W-1:0] driver;
   } force_pair_type;

   typedef struct {
      logic signed [POS_W-1:0] position;
      logic signed [VEL_W-1:0] velocity;
      logic                    moving;
   } wheel_state_type;

   typedef struct {
      logic [BRK_W-1:0]    breakaway;
      logic [KIN_W-1:0]    kinetic;
      logic [SLOPE_W-1:0]  slope;
      logic [VMAX_W-1:0]   vmax;
      logic [LAG_W-1:0]    lag;
      logic [PERIOD_W-1:0] period;
      logic [DELAY_W-1:0]  delay;
   } plant_settings_type;

   localparam plant_settings_type RESET_SETTINGS = '{BRK_RESET, KIN_RESET, SLOPE_RESET,
                                                     VMAX_RESET, LAG_RESET, PERIOD_RESET,
                                                     DELAY_RESET};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       send_valid  = 1'b0;
   logic signed [FORCE_W-1:0]  send_servo  = '0;
   logic signed [FORCE_W-1:0]  send_driver = '0;
   logic                       accept_ready = 1'b0;

   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   sswp_req_if req_ch ();
   sswp_rsp_if rsp_ch ();

   assign req_ch.valid        = send_valid;
   assign req_ch.servo_drive  = send_servo;
   assign req_ch.driver_force = send_driver;
   assign rsp_ch.ready        = accept_ready;

   stick_slip_wheel_plant dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the plant: register copy and the friction state.
   plant_settings_type active_cfg = RESET_SETTINGS;
   longint          force_ring [HIST_DEPTH];
   int              ring_wr    = 0;
   int              ring_fill  = 0;
   bit              wheel_moving = 1'b0;
   longint          wheel_vel  = 0;
   longint          wheel_pos  = 0;

   force_pair_type  pending_frames[$];
   wheel_state_type predicted_frames[$];
   int              fault_count  = 0;
   bit              idle_enabled = 1'b1;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #2_400_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Product rounded half away from zero, then scaled down by 16 bits.
   function automatic longint round_mul16(input longint a, input longint b);
      longint mag;
      longint r;
      mag = (a < 0 ? -a : a) * b;
      r = (mag + 32768) >>> 16;
      return a < 0 ? -r : r;
   endfunction

   function automatic wheel_state_type advance_frame(input logic signed [FORCE_W-1:0] servo,
                                                     input logic signed [FORCE_W-1:0] driver);
      wheel_state_type r;
      longint          net, f, mag, excess, sp, vt;
      int              newest, back;
      if (active_cfg.period != 0) begin
         net = longint'(servo) + longint'(driver);
         newest = ring_wr;
         force_ring[newest] = net;
         ring_wr = (newest + 1) % HIST_DEPTH;
         if (ring_fill < HIST_DEPTH) ring_fill++;
         // Until the ring has filled, the oldest written entry is the furthest back we can go.
         back = int'(active_cfg.delay);
         if (back > ring_fill - 1) back = ring_fill - 1;
         f = force_ring[(newest + HIST_DEPTH - back) % HIST_DEPTH];
         mag = f < 0 ? -f : f;

         if (!wheel_moving) begin
            if (mag < longint'(active_cfg.breakaway)) wheel_vel = 0;
            else wheel_moving = 1'b1;
         end
         if (wheel_moving) begin
            excess = mag - longint'(active_cfg.kinetic);
            if (excess <= 0) begin
               wheel_vel = 0;
               wheel_moving = 1'b0;
            end else begin
               sp = (excess * longint'(active_cfg.slope) + 2048) >>> 12;
               if (sp > longint'(active_cfg.vmax)) sp = longint'(active_cfg.vmax);
               vt = f >= 0 ? -sp : sp;
               if (active_cfg.lag != 0)
                  wheel_vel = vt + round_mul16(wheel_vel - vt, longint'(active_cfg.lag));
               else
                  wheel_vel = vt;
            end
         end

         wheel_pos += round_mul16(wheel_vel, longint'(active_cfg.period));
         if (wheel_pos > POS_LIMIT) wheel_pos = POS_LIMIT;
         if (wheel_pos < -POS_LIMIT) wheel_pos = -POS_LIMIT;
      end
      r.position = POS_W'(wheel_pos);
      r.velocity = VEL_W'(wheel_vel);
      r.moving   = wheel_moving;
      return r;
   endfunction

   always @(posedge clock) begin : feed
      force_pair_type nxt;
      int             gap_left;
      if (reset) begin
         send_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (send_valid && req_ch.ready)
            predicted_frames.insert(predicted_frames.size(),
                                    advance_frame(send_servo, send_driver));
         if (!send_valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               send_valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               nxt = pending_frames[0];
               pending_frames.delete(0);
               send_servo  <= nxt.servo;
               send_driver <= nxt.driver;
               send_valid  <= 1'b1;
               if (idle_enabled && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
            end else begin
               send_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      wheel_state_type want;
      int              hold_off;
      if (reset) begin
         accept_ready <= 1'b0;
         hold_off = 0;
      end else begin
         if (rsp_ch.valid && accept_ready) begin
            if (predicted_frames.size() == 0) begin
               $error("result item with no expected item waiting");
               fault_count++;
            end else begin
               want = predicted_frames[0];
               predicted_frames.delete(0);
               if (rsp_ch.wheel_position !== want.position) begin
                  $error("wheel_position: expected %0d, actual %0d",
                         want.position, rsp_ch.wheel_position);
                  fault_count++;
               end
               if (rsp_ch.wheel_velocity !== want.velocity) begin
                  $error("wheel_velocity: expected %0d, actual %0d",
                         want.velocity, rsp_ch.wheel_velocity);
                  fault_count++;
               end
               if (rsp_ch.is_moving !== want.moving) begin
                  $error("is_moving: expected %0d, actual %0d", want.moving, rsp_ch.is_moving);
                  fault_count++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            accept_ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            hold_off = $urandom_range(1, 9) - 1;
            accept_ready <= 1'b0;
         end else begin
            accept_ready <= 1'b1;
         end
      end
   end

   task automatic write_register(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BREAKAWAY: active_cfg.breakaway = value[BRK_W-1:0];
         REG_KINETIC:   active_cfg.kinetic   = value[KIN_W-1:0];
         REG_SLOPE:     active_cfg.slope     = value[SLOPE_W-1:0];
         REG_MAX_SPEED: active_cfg.vmax      = value[VMAX_W-1:0];
         REG_LAG:       active_cfg.lag       = value[LAG_W-1:0];
         REG_PERIOD:    active_cfg.period    = value[PERIOD_W-1:0];
         REG_DELAY:     active_cfg.delay     = value[DELAY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input plant_settings_type s);
      write_register(REG_BREAKAWAY, CSR_DATA_W'(s.breakaway));
      write_register(REG_KINETIC,   CSR_DATA_W'(s.kinetic));
      write_register(REG_SLOPE,     CSR_DATA_W'(s.slope));
      write_register(REG_MAX_SPEED, CSR_DATA_W'(s.vmax));
      write_register(REG_LAG,       CSR_DATA_W'(s.lag));
      write_register(REG_PERIOD,    CSR_DATA_W'(s.period));
      write_register(REG_DELAY,     CSR_DATA_W'(s.delay));
   endtask

   // Mostly a value up to typical_hi, with each end of the legal range now and then.
   function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                        input int unsigned typical_hi);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return lo;
      if (roll < 20) return hi;
      return $urandom_range(lo, typical_hi);
   endfunction

   function automatic plant_settings_type random_settings();
      plant_settings_type s;
      s.breakaway = BRK_W'(pick(0, 131071, 40000));
      s.kinetic   = KIN_W'(pick(0, 131071, 30000));
      s.slope     = SLOPE_W'(pick(0, 32767, 32767));
      s.vmax      = VMAX_W'(pick(0, 262143, 262143));
      s.lag       = LAG_W'(pick(0, 65535, 65535));
      s.period    = PERIOD_W'(pick(1, 65535, 65535));
      s.delay     = DELAY_W'(pick(0, 15, 15));
      return s;
   endfunction

   task automatic push_frame(input int servo, input int driver);
      force_pair_type p;
      p.servo  = FORCE_W'(servo);
      p.driver = FORCE_W'(driver);
      pending_frames.insert(pending_frames.size(), p);
   endtask

   // Runs of nearly steady force around the friction thresholds let the wheel break away,
   // slide and stick again; full-range noise and extreme pairs are mixed in.
   task automatic queue_random_frames(input int count);
      int extremes [5] = '{FORCE_MIN, -1, 0, 1, FORCE_MAX};
      int roll, run, base, net, lo, hi, servo;
      while (count > 0) begin
         roll = $urandom_range(0, 99);
         run  = $urandom_range(1, 12);
         if (roll < 45) base = int'(active_cfg.breakaway) + int'($urandom_range(0, 600)) - 300;
         else if (roll < 70) base = int'(active_cfg.kinetic) + int'($urandom_range(0, 600)) - 300;
         else base = $urandom_range(0, 262143);
         if ($urandom_range(0, 1) == 1) base = -base;
         for (int k = 0; k < run && count > 0; k++) begin
            if (roll >= 95) begin
               push_frame(extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)]);
            end else if (roll >= 85) begin
               push_frame(int'(FORCE_W'($urandom)), int'(FORCE_W'($urandom)));
            end else begin
               if ($urandom_range(0, 9) == 0) base = -base;
               net = base + int'($urandom_range(0, 400)) - 200;
               if (net > 2 * FORCE_MAX) net = 2 * FORCE_MAX;
               if (net < 2 * FORCE_MIN) net = 2 * FORCE_MIN;
               lo = (net - FORCE_MAX > FORCE_MIN) ? net - FORCE_MAX : FORCE_MIN;
               hi = (net - FORCE_MIN < FORCE_MAX) ? net - FORCE_MIN : FORCE_MAX;
               servo = lo + int'($urandom_range(0, hi - lo));
               push_frame(servo, net - servo);
            end
            count--;
         end
      end
   endtask

   // Checked at the falling edge so that the driver and monitor of the last rising edge
   // have already updated the queues and the valid flag.
   task automatic settle();
      while (pending_frames.size() != 0 || send_valid || predicted_frames.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      plant_settings_type s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Longest dead time on an empty ring: every frame reads the first force written.
      s = RESET_SETTINGS;
      s.delay = 4'd15;
      apply_settings(s);
      push_frame(20000, 0);
      push_frame(0, 0);
      push_frame(-50000, -1);
      push_frame(FORCE_MAX, FORCE_MAX);
      settle();

      // Default friction: just below and at breakaway, sliding on, falling back at kinetic.
      apply_settings(RESET_SETTINGS);
      push_frame(0, 0);
      push_frame(6225, 0);
      push_frame(6226, 0);
      push_frame(3000, 3000);
      push_frame(5243, 0);
      push_frame(FORCE_MIN, FORCE_MIN);
      push_frame(FORCE_MAX, FORCE_MAX);
      push_frame(FORCE_MAX, FORCE_MIN);
      push_frame(-6226, 0);
      settle();

      // No friction, top speed and longest frame: zero force and both full-lock clamps.
      s = '{17'd0, 17'd0, 15'd32767, 18'd262143, 16'd0, 16'd65535, 4'd0};
      apply_settings(s);
      push_frame(0, 0);
      push_frame(FORCE_MAX, FORCE_MAX);
      push_frame(FORCE_MAX, FORCE_MAX);
      push_frame(FORCE_MIN, FORCE_MIN);
      push_frame(FORCE_MIN, FORCE_MIN);
      settle();

      // A zero frame period freezes the plant.
      s.period = '0;
      write_register(REG_PERIOD, CSR_DATA_W'(s.period));
      push_frame(1234, -5678);
      push_frame(FORCE_MIN, FORCE_MAX);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         idle_enabled = (ph == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (ph == 0) s = '{BRK_RESET, KIN_RESET, SLOPE_RESET, 18'd262143, 16'd65535,
                            16'd1, 4'd15};
         else s = random_settings();
         apply_settings(s);
         queue_random_frames(92);
         settle();
      end

      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/sswp_pkg.sv
rtl/sswp_if.sv
rtl/sswp_ram.sv
rtl/stick_slip_wheel_plant.sv
tb/sv/tb.sv
